/* design/anchor_retrieval_sequencer_defines.svh */
// Assertion macros shared by the anchor retrieval sequencer RTL.
// Expects clk and arst_n in the scope where the macros are used.
`ifndef ANCHOR_RETRIEVAL_SEQUENCER_DEFINES_SVH
`define ANCHOR_RETRIEVAL_SEQUENCER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define ARC_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset.
`define ARC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* design/arc_pkg.sv */
// Shared types and constants for the anchor retrieval sequencer.
// No dependencies; used by arc_cfg_regs, arc_step_logic and the top level.
package arc_pkg;

	localparam int LEN_W   = 21;  // signed length fields on the input side
	localparam int CFG_W   = 20;  // widest configuration register
	localparam int TIME_W  = 32;
	localparam int CD_W    = 16;  // cooldown and ratio width
	localparam int RAISE_W = 20;
	localparam int IDX_W   = 3;
	localparam int CMP_W   = 23;  // signed width for length comparisons

	// A final pull is commanded only when it exceeds this
	localparam logic signed [CMP_W-1:0] FINAL_MIN_MM = 23'sd100;

	// Register indexes
	localparam logic [IDX_W-1:0] REG_COMPLETION = 3'd0;
	localparam logic [IDX_W-1:0] REG_FINAL_PULL = 3'd1;
	localparam logic [IDX_W-1:0] REG_COOLDOWN   = 3'd2;
	localparam logic [IDX_W-1:0] REG_RATIO      = 3'd3;
	localparam logic [IDX_W-1:0] REG_PAUSE      = 3'd4;
	localparam logic [IDX_W-1:0] REG_MIN_RAISE  = 3'd5;

	// Register reset values
	localparam logic [CFG_W-1:0] RST_COMPLETION = 20'd2000;
	localparam logic [CFG_W-1:0] RST_FINAL_PULL = 20'd10000;
	localparam logic [CD_W-1:0]  RST_COOLDOWN   = 16'd3000;
	localparam logic [CD_W-1:0]  RST_RATIO      = 16'd77;
	localparam logic [CFG_W-1:0] RST_PAUSE      = 20'd200;
	localparam logic [CFG_W-1:0] RST_MIN_RAISE  = 20'd1000;

	typedef enum logic [1:0] {
		OP_TICK  = 2'd0,
		OP_START = 2'd1,
		OP_STOP  = 2'd2
	} op_t;

	typedef enum logic [1:0] {
		CMD_NONE  = 2'd0,
		CMD_RAISE = 2'd1,
		CMD_STOP  = 2'd2
	} cmd_t;

	typedef enum logic [2:0] {
		PH_IDLE  = 3'd0,
		PH_CHECK = 3'd1,
		PH_RAISE = 3'd2,
		PH_WAIT  = 3'd3,
		PH_DONE  = 3'd4
	} phase_t;

	typedef struct packed {
		logic [CFG_W-1:0] completion_mm;
		logic [CFG_W-1:0] final_pull_mm;
		logic [CD_W-1:0]  cooldown_ms;
		logic [CD_W-1:0]  resume_ratio_q8;
		logic [CFG_W-1:0] pause_slack_mm;
		logic [CFG_W-1:0] min_raise_mm;
	} cfg_t;

	typedef struct packed {
		logic [1:0]              opcode;
		logic signed [LEN_W-1:0] rode_mm;
		logic signed [LEN_W-1:0] depth_mm;
		logic signed [LEN_W-1:0] slack_mm;
		logic [TIME_W-1:0]       now_ms;
		logic                    winch_active;
		logic                    winch_busy;
	} item_t;

	typedef struct packed {
		phase_t            phase;
		logic              running;
		logic              complete;
		logic [TIME_W-1:0] last_raise_ms;
	} state_t;

	typedef struct packed {
		cmd_t               motor_command;
		logic [RAISE_W-1:0] raise_mm;
		phase_t             phase;
		logic               is_running;
		logic               is_complete;
		logic               finished_pulse;
	} result_t;

endpackage

/* design/anchor_retrieval_sequencer.sv */
// Anchor retrieval sequencer: top level with input and result registers.
// Depends on arc_pkg, arc_cfg_regs, arc_step_logic and the assertion macro header.
//
// Usage:
//   Input channel (in_valid / in_stall) carries one transaction per item: a start,
//   a stop or a periodic tick with rode, depth, slack, time and winch flags.
//   Output channel (out_valid / out_stall) returns exactly one result per item:
//   motor command, raise amount, phase and the running/complete/finished flags.
//   Configuration: a write on cfg_wr_en lands cfg_data in register cfg_index at
//   the same edge; writes to unmapped indexes are dropped. Write only while idle.
// Pipeline: two register stages, the input register and then the result register,
//   lie between an accepted transaction and its result on the output.
// Throughput: one transaction per cycle while the receiver does not stall; the sequencer
//   state updates in combinational logic between the two registers, and the slack-versus-depth
//   product (one 21x17 multiply) sets the critical path.
// Stall: when out_stall holds a full result register, the input register holds
//   its transaction and in_stall rises; an empty input register never stalls.
// Reset: arst_n clears both valid bits, returns the phase to idle, clears the
//   flags and the last raise time, and loads the default configuration.
`include "anchor_retrieval_sequencer_defines.svh"

module anchor_retrieval_sequencer (
	input  logic                                clk,
	input  logic                                arst_n,
	// configuration write port
	input  logic                                cfg_wr_en,
	input  logic [arc_pkg::IDX_W-1:0]           cfg_index,
	input  logic [arc_pkg::CFG_W-1:0]           cfg_data,
	// input channel
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [1:0]                          opcode,
	input  logic signed [arc_pkg::LEN_W-1:0]    rode_mm,
	input  logic signed [arc_pkg::LEN_W-1:0]    depth_mm,
	input  logic signed [arc_pkg::LEN_W-1:0]    slack_mm,
	input  logic [arc_pkg::TIME_W-1:0]          now_ms,
	input  logic                                winch_active,
	input  logic                                winch_busy,
	// output channel
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [1:0]                          motor_command,
	output logic [arc_pkg::RAISE_W-1:0]         raise_mm,
	output logic [2:0]                          phase,
	output logic                                is_running,
	output logic                                is_complete,
	output logic                                finished_pulse
);

	arc_pkg::cfg_t    cfg;
	arc_pkg::item_t   item_s1;
	arc_pkg::result_t res_s2, res_next;
	arc_pkg::state_t  state_q, state_next;
	logic             valid_s1, valid_s2;
	logic             accept, advance;

	arc_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	arc_step_logic u_step (
		.cfg  (cfg),
		.cur  (state_q),
		.item (item_s1),
		.nxt  (state_next),
		.res  (res_next)
	);

	// Advance the input register into the result register whenever the result
	// register is empty or its transaction is being taken this cycle.
	assign advance  = valid_s1 && (!valid_s2 || !out_stall);
	assign in_stall = valid_s1 && !advance;
	assign accept   = in_valid && !in_stall;

	// Input register: payload needs no reset.
	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1.opcode       <= opcode;
			item_s1.rode_mm      <= rode_mm;
			item_s1.depth_mm     <= depth_mm;
			item_s1.slack_mm     <= slack_mm;
			item_s1.now_ms       <= now_ms;
			item_s1.winch_active <= winch_active;
			item_s1.winch_busy   <= winch_busy;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	// Sequencer state: commit only when the transaction moves to the output.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.phase         <= arc_pkg::PH_IDLE;
			state_q.running       <= 1'b0;
			state_q.complete      <= 1'b0;
			state_q.last_raise_ms <= '0;
		end else if (advance) begin
			state_q <= state_next;
		end
	end

	// Result register: hold while the receiver stalls.
	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= res_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (!out_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	assign out_valid      = valid_s2;
	assign motor_command  = res_s2.motor_command;
	assign raise_mm       = res_s2.raise_mm;
	assign phase          = res_s2.phase;
	assign is_running     = res_s2.is_running;
	assign is_complete    = res_s2.is_complete;
	assign finished_pulse = res_s2.finished_pulse;

	// A running sequence is never in idle, and an idle one is never running.
	`ARC_ASSERT_NOW(a_run_phase, 1'b1, state_q.running == (state_q.phase != arc_pkg::PH_IDLE), "running flag and phase disagree")
	// Completion always ends the run.
	`ARC_ASSERT_NOW(a_run_done, state_q.running, !state_q.complete, "complete while still running")
	// A finished transaction reports an idle, stopped sequence.
	`ARC_ASSERT_NOW(a_fin_idle, valid_s2 && res_s2.finished_pulse, !res_s2.is_running && res_s2.phase == arc_pkg::PH_IDLE, "finish reported without stop")
	// Without an advancing transaction the sequencer state holds.
	`ARC_ASSERT_NEXT(a_state_hold, !advance, $stable(state_q), "state changed without a transaction")

endmodule

/* design/arc_cfg_regs.sv */
// Configuration register file for the anchor retrieval sequencer.
// Depends on arc_pkg for register indexes, reset values and cfg_t.
module arc_cfg_regs (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_wr_en,
	input  logic [arc_pkg::IDX_W-1:0]      cfg_index,
	input  logic [arc_pkg::CFG_W-1:0]      cfg_data,
	output arc_pkg::cfg_t                  cfg
);

	arc_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.completion_mm   <= arc_pkg::RST_COMPLETION;
			cfg_q.final_pull_mm   <= arc_pkg::RST_FINAL_PULL;
			cfg_q.cooldown_ms     <= arc_pkg::RST_COOLDOWN;
			cfg_q.resume_ratio_q8 <= arc_pkg::RST_RATIO;
			cfg_q.pause_slack_mm  <= arc_pkg::RST_PAUSE;
			cfg_q.min_raise_mm    <= arc_pkg::RST_MIN_RAISE;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				arc_pkg::REG_COMPLETION: cfg_q.completion_mm   <= cfg_data;
				arc_pkg::REG_FINAL_PULL: cfg_q.final_pull_mm   <= cfg_data;
				arc_pkg::REG_COOLDOWN:   cfg_q.cooldown_ms     <= cfg_data[arc_pkg::CD_W-1:0];
				arc_pkg::REG_RATIO:      cfg_q.resume_ratio_q8 <= cfg_data[arc_pkg::CD_W-1:0];
				arc_pkg::REG_PAUSE:      cfg_q.pause_slack_mm  <= cfg_data;
				arc_pkg::REG_MIN_RAISE:  cfg_q.min_raise_mm    <= cfg_data;
				default: begin
					// drop writes to unmapped indexes
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

/* design/arc_step_logic.sv */
// Next-state and result logic for one retrieval transaction.
// Purely combinational; depends on arc_pkg types.
module arc_step_logic (
	input  arc_pkg::cfg_t    cfg,
	input  arc_pkg::state_t  cur,
	input  arc_pkg::item_t   item,
	output arc_pkg::state_t  nxt,
	output arc_pkg::result_t res
);

	localparam int CW = arc_pkg::CMP_W;
	localparam int PW = arc_pkg::LEN_W + arc_pkg::CD_W + 1;

	logic signed [CW-1:0] rode_x, depth_x, slack_x;
	logic signed [CW-1:0] comp_x, final_x, pause_x, min_x;
	logic signed [CW-1:0] final_amt;
	logic signed [PW-1:0] slack_sh, depth_prod;
	logic [arc_pkg::TIME_W-1:0] elapsed;
	logic final_zone, cooled, slack_ok, at_completion;
	arc_pkg::cmd_t cmd;
	logic [arc_pkg::RAISE_W-1:0] amount;
	logic pulse, do_stop;

	assign rode_x  = CW'(item.rode_mm);
	assign depth_x = CW'(item.depth_mm);
	assign slack_x = CW'(item.slack_mm);
	assign comp_x  = $signed({3'b000, cfg.completion_mm});
	assign final_x = $signed({3'b000, cfg.final_pull_mm});
	assign pause_x = $signed({3'b000, cfg.pause_slack_mm});
	assign min_x   = $signed({3'b000, cfg.min_raise_mm});

	assign final_zone    = rode_x < (depth_x + final_x);
	assign at_completion = rode_x <= comp_x;
	assign final_amt     = rode_x - comp_x;

	assign elapsed = item.now_ms - cur.last_raise_ms;
	assign cooled  = elapsed >= {{(arc_pkg::TIME_W-arc_pkg::CD_W){1'b0}}, cfg.cooldown_ms};

	// slack*256 against depth*ratio, exact in signed arithmetic
	assign slack_sh   = {{(PW-arc_pkg::LEN_W-8){item.slack_mm[arc_pkg::LEN_W-1]}},
		item.slack_mm, 8'b0};
	assign depth_prod = PW'(item.depth_mm) * PW'($signed({1'b0, cfg.resume_ratio_q8}));
	assign slack_ok   = slack_sh >= depth_prod;

	always_comb begin
		nxt     = cur;
		cmd     = arc_pkg::CMD_NONE;
		amount  = '0;
		pulse   = 1'b0;
		do_stop = 1'b0;

		unique case (item.opcode)
			arc_pkg::OP_START: begin
				if (!cur.running) begin
					nxt.running       = 1'b1;
					nxt.complete      = 1'b0;
					nxt.phase         = arc_pkg::PH_CHECK;
					nxt.last_raise_ms = '0;
				end
			end
			arc_pkg::OP_STOP: begin
				do_stop = cur.running;
			end
			arc_pkg::OP_TICK: begin
				if (cur.running) begin
					unique case (cur.phase)
						arc_pkg::PH_CHECK: begin
							if (at_completion) begin
								nxt.phase    = arc_pkg::PH_DONE;
								nxt.complete = 1'b1;
								do_stop      = 1'b1;
							end else if (item.winch_busy) begin
								// controller owns the winch; hold
							end else if (final_zone) begin
								if (!cooled) begin
									nxt.phase = arc_pkg::PH_WAIT;
								end else if (final_amt > arc_pkg::FINAL_MIN_MM) begin
									cmd               = arc_pkg::CMD_RAISE;
									amount            = final_amt[arc_pkg::RAISE_W-1:0];
									nxt.last_raise_ms = item.now_ms;
									nxt.phase         = arc_pkg::PH_RAISE;
								end
							end else if (cooled && slack_ok && slack_x >= min_x) begin
								cmd               = arc_pkg::CMD_RAISE;
								amount            = item.slack_mm[arc_pkg::RAISE_W-1:0];
								nxt.last_raise_ms = item.now_ms;
								nxt.phase         = arc_pkg::PH_RAISE;
							end else begin
								nxt.phase = arc_pkg::PH_WAIT;
							end
						end
						arc_pkg::PH_RAISE: begin
							if (!final_zone && slack_x < pause_x && item.winch_active) begin
								cmd               = arc_pkg::CMD_STOP;
								nxt.last_raise_ms = item.now_ms;
								nxt.phase         = arc_pkg::PH_WAIT;
							end else if (!item.winch_active) begin
								nxt.phase = arc_pkg::PH_WAIT;
							end
						end
						arc_pkg::PH_WAIT: begin
							if (at_completion || (final_zone && cooled) || (slack_ok && cooled)) begin
								nxt.phase = arc_pkg::PH_CHECK;
							end
						end
						default: begin
						end
					endcase
				end
			end
			default: begin
			end
		endcase

		if (do_stop) begin
			nxt.running = 1'b0;
			nxt.phase   = arc_pkg::PH_IDLE;
			if (item.winch_active) begin
				cmd = arc_pkg::CMD_STOP;
			end
			pulse = 1'b1;
		end

		res.motor_command  = cmd;
		res.raise_mm       = (cmd == arc_pkg::CMD_RAISE) ? amount : '0;
		res.phase          = nxt.phase;
		res.is_running     = nxt.running;
		res.is_complete    = nxt.complete;
		res.finished_pulse = pulse;
	end

endmodule

/* tb/sv/anchor_retrieval_sequencer_tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for anchor_retrieval_sequencer: directed cases, then random
// retrieval sessions under several register settings and flow-control patterns.
// Depends on arc_pkg and the anchor_retrieval_sequencer RTL only.

module anchor_retrieval_sequencer_tb;

	// opcode value the block must treat as a no-op
	localparam logic [1:0] OP_UNUSED = 2'd3;
	localparam int WATCHDOG_LIMIT = 5000;
	// two register stages, plus margin
	localparam int DRAIN_CYCLES = 4;
	localparam arc_pkg::cfg_t DEFAULT_CFG = '{arc_pkg::RST_COMPLETION,
		arc_pkg::RST_FINAL_PULL, arc_pkg::RST_COOLDOWN, arc_pkg::RST_RATIO,
		arc_pkg::RST_PAUSE, arc_pkg::RST_MIN_RAISE};

	logic                             clk;
	logic                             arst_n = 1'b0;
	logic                             cfg_wr_en = 1'b0;
	logic [arc_pkg::IDX_W-1:0]        cfg_index = '0;
	logic [arc_pkg::CFG_W-1:0]        cfg_data = '0;
	logic                             in_valid = 1'b0;
	logic                             in_stall;
	logic [1:0]                       opcode = '0;
	logic signed [arc_pkg::LEN_W-1:0] rode_mm = '0;
	logic signed [arc_pkg::LEN_W-1:0] depth_mm = '0;
	logic signed [arc_pkg::LEN_W-1:0] slack_mm = '0;
	logic [arc_pkg::TIME_W-1:0]       now_ms = '0;
	logic                             winch_active = 1'b0;
	logic                             winch_busy = 1'b0;
	logic                             out_valid;
	logic                             out_stall = 1'b0;
	logic [1:0]                       motor_command;
	logic [arc_pkg::RAISE_W-1:0]      raise_mm;
	logic [2:0]                       phase;
	logic                             is_running;
	logic                             is_complete;
	logic                             finished_pulse;

	// Mirror of the sequencer state and its registers
	arc_pkg::state_t seq_state = '{phase: arc_pkg::PH_IDLE, running: 1'b0, complete: 1'b0,
		last_raise_ms: '0};
	arc_pkg::cfg_t   seq_cfg = DEFAULT_CFG;

	// Outcomes predicted for accepted transactions, oldest first
	arc_pkg::result_t awaited_outcomes[$];
	arc_pkg::result_t want;

	// Percent chance per cycle that the sender idles / the receiver stalls
	int idle_pct = 0;
	int stall_pct = 0;

	int n_items = 0;
	int n_checked = 0;
	int n_raises = 0;
	int n_completions = 0;
	int n_configs = 0;
	int n_errors = 0;
	int quiet_cycles = 0;

	anchor_retrieval_sequencer dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_wr_en      (cfg_wr_en),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.opcode         (opcode),
		.rode_mm        (rode_mm),
		.depth_mm       (depth_mm),
		.slack_mm       (slack_mm),
		.now_ms         (now_ms),
		.winch_active   (winch_active),
		.winch_busy     (winch_busy),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.motor_command  (motor_command),
		.raise_mm       (raise_mm),
		.phase          (phase),
		.is_running     (is_running),
		.is_complete    (is_complete),
		.finished_pulse (finished_pulse)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Advance the mirrored sequencer by one transaction and return what the block
	// must report for it. All length math runs in 64 bits so nothing overflows.
	function automatic arc_pkg::result_t next_sequencer_outcome(arc_pkg::item_t it);
		arc_pkg::result_t r;
		longint rode, depth, slack, amount;
		logic [arc_pkg::TIME_W-1:0] elapsed;
		logic halt, zone, cooled, slack_ok;
		rode = it.rode_mm;
		depth = it.depth_mm;
		slack = it.slack_mm;
		amount = 0;
		halt = 1'b0;
		r = '0;
		r.motor_command = arc_pkg::CMD_NONE;
		r.finished_pulse = 1'b0;
		zone = rode < depth + longint'(seq_cfg.final_pull_mm);
		// elapsed time wraps modulo 2^32
		elapsed = it.now_ms - seq_state.last_raise_ms;
		cooled = elapsed >= arc_pkg::TIME_W'(seq_cfg.cooldown_ms);
		slack_ok = slack * 256 >= depth * longint'(seq_cfg.resume_ratio_q8);
		case (it.opcode)
			arc_pkg::OP_START: begin
				// a start while running changes nothing
				if (!seq_state.running) begin
					seq_state.running = 1'b1;
					seq_state.complete = 1'b0;
					seq_state.phase = arc_pkg::PH_CHECK;
					seq_state.last_raise_ms = '0;
				end
			end
			arc_pkg::OP_STOP: halt = seq_state.running;
			arc_pkg::OP_TICK: begin
				if (seq_state.running) begin
					case (seq_state.phase)
						arc_pkg::PH_CHECK: begin
							if (rode <= longint'(seq_cfg.completion_mm)) begin
								seq_state.phase = arc_pkg::PH_DONE;
								seq_state.complete = 1'b1;
								halt = 1'b1;
							end else if (it.winch_busy) begin
								// hold while the chain controller is busy
							end else if (zone) begin
								if (!cooled) begin
									seq_state.phase = arc_pkg::PH_WAIT;
								end else begin
									amount = rode - longint'(seq_cfg.completion_mm);
									// too short a final pull stays in checking
									if (amount > longint'(arc_pkg::FINAL_MIN_MM)) begin
										r.motor_command = arc_pkg::CMD_RAISE;
										seq_state.last_raise_ms = it.now_ms;
										seq_state.phase = arc_pkg::PH_RAISE;
									end
								end
							end else if (cooled && slack_ok &&
									slack >= longint'(seq_cfg.min_raise_mm)) begin
								r.motor_command = arc_pkg::CMD_RAISE;
								amount = slack;
								seq_state.last_raise_ms = it.now_ms;
								seq_state.phase = arc_pkg::PH_RAISE;
							end else begin
								seq_state.phase = arc_pkg::PH_WAIT;
							end
						end
						arc_pkg::PH_RAISE: begin
							if (!zone && slack < longint'(seq_cfg.pause_slack_mm) &&
									it.winch_active) begin
								// pause also restarts the cooldown
								r.motor_command = arc_pkg::CMD_STOP;
								seq_state.last_raise_ms = it.now_ms;
								seq_state.phase = arc_pkg::PH_WAIT;
							end else if (!it.winch_active) begin
								seq_state.phase = arc_pkg::PH_WAIT;
							end
						end
						arc_pkg::PH_WAIT: begin
							if (rode <= longint'(seq_cfg.completion_mm))
								seq_state.phase = arc_pkg::PH_CHECK;
							else if (zone && cooled)
								seq_state.phase = arc_pkg::PH_CHECK;
							else if (slack_ok && cooled)
								seq_state.phase = arc_pkg::PH_CHECK;
						end
						default: ;
					endcase
				end
			end
			default: ;
		endcase
		// completion and an explicit stop share the same shutdown
		if (halt) begin
			seq_state.running = 1'b0;
			seq_state.phase = arc_pkg::PH_IDLE;
			if (it.winch_active)
				r.motor_command = arc_pkg::CMD_STOP;
			r.finished_pulse = 1'b1;
		end
		r.raise_mm = (r.motor_command == arc_pkg::CMD_RAISE) ?
			amount[arc_pkg::RAISE_W-1:0] : '0;
		r.phase = seq_state.phase;
		r.is_running = seq_state.running;
		r.is_complete = seq_state.complete;
		return r;
	endfunction

	function automatic arc_pkg::item_t make_item(logic [1:0] op, longint rode,
			longint depth, longint slack, logic [arc_pkg::TIME_W-1:0] now, bit act,
			bit busy);
		arc_pkg::item_t it;
		it.opcode = op;
		it.rode_mm = rode[arc_pkg::LEN_W-1:0];
		it.depth_mm = depth[arc_pkg::LEN_W-1:0];
		it.slack_mm = slack[arc_pkg::LEN_W-1:0];
		it.now_ms = now;
		it.winch_active = act;
		it.winch_busy = busy;
		return it;
	endfunction

	// Every bit of every field random, opcode included
	function automatic arc_pkg::item_t random_item();
		arc_pkg::item_t it;
		it.opcode = 2'($urandom());
		it.rode_mm = arc_pkg::LEN_W'($urandom());
		it.depth_mm = arc_pkg::LEN_W'($urandom());
		it.slack_mm = arc_pkg::LEN_W'($urandom());
		it.now_ms = $urandom();
		it.winch_active = 1'($urandom());
		it.winch_busy = 1'($urandom());
		return it;
	endfunction

	function automatic arc_pkg::cfg_t random_config();
		arc_pkg::cfg_t c;
		c.completion_mm = arc_pkg::CFG_W'($urandom_range(5000));
		c.final_pull_mm = arc_pkg::CFG_W'($urandom_range(30000));
		c.cooldown_ms = arc_pkg::CD_W'($urandom_range(5000));
		c.resume_ratio_q8 = arc_pkg::CD_W'($urandom_range(300));
		c.pause_slack_mm = arc_pkg::CFG_W'($urandom_range(3000));
		c.min_raise_mm = arc_pkg::CFG_W'($urandom_range(5000));
		return c;
	endfunction

	// Drive one transaction, hold it until accepted, then record its outcome.
	// Called and returns in the time step of a rising edge.
	task automatic send_item(arc_pkg::item_t it);
		arc_pkg::result_t outcome;
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		opcode <= it.opcode;
		rode_mm <= it.rode_mm;
		depth_mm <= it.depth_mm;
		slack_mm <= it.slack_mm;
		now_ms <= it.now_ms;
		winch_active <= it.winch_active;
		winch_busy <= it.winch_busy;
		do @(posedge clk); while (in_stall);
		outcome = next_sequencer_outcome(it);
		awaited_outcomes.push_back(outcome);
		n_items++;
		if (outcome.motor_command == arc_pkg::CMD_RAISE)
			n_raises++;
		if (outcome.finished_pulse && outcome.is_complete)
			n_completions++;
	endtask

	// Stop sending and wait until every awaited result has come back
	task automatic drain_results();
		in_valid <= 1'b0;
		while (awaited_outcomes.size() != 0)
			@(posedge clk);
	endtask

	// Write one register; the enable stays high for back-to-back writes
	task automatic write_reg(logic [arc_pkg::IDX_W-1:0] idx,
			logic [arc_pkg::CFG_W-1:0] data);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		case (idx)
			arc_pkg::REG_COMPLETION: seq_cfg.completion_mm = data;
			arc_pkg::REG_FINAL_PULL: seq_cfg.final_pull_mm = data;
			arc_pkg::REG_COOLDOWN:   seq_cfg.cooldown_ms = data[arc_pkg::CD_W-1:0];
			arc_pkg::REG_RATIO:      seq_cfg.resume_ratio_q8 = data[arc_pkg::CD_W-1:0];
			arc_pkg::REG_PAUSE:      seq_cfg.pause_slack_mm = data;
			arc_pkg::REG_MIN_RAISE:  seq_cfg.min_raise_mm = data;
			default: ;
		endcase
	endtask

	// Reprogram every register while the block is idle
	task automatic apply_config(arc_pkg::cfg_t c);
		drain_results();
		write_reg(arc_pkg::REG_COMPLETION, c.completion_mm);
		write_reg(arc_pkg::REG_FINAL_PULL, c.final_pull_mm);
		write_reg(arc_pkg::REG_COOLDOWN, arc_pkg::CFG_W'(c.cooldown_ms));
		write_reg(arc_pkg::REG_RATIO, arc_pkg::CFG_W'(c.resume_ratio_q8));
		write_reg(arc_pkg::REG_PAUSE, c.pause_slack_mm);
		write_reg(arc_pkg::REG_MIN_RAISE, c.min_raise_mm);
		cfg_wr_en <= 1'b0;
		n_configs++;
	endtask

	// Mostly well-formed retrievals: a start, a run of ticks with the rode
	// shrinking and time advancing, and often a stop. The rest is noise.
	task automatic run_retrievals(int n);
		int sent, ticks;
		longint rode, depth, slack;
		logic [arc_pkg::TIME_W-1:0] now;
		logic [1:0] op;
		arc_pkg::item_t it;
		sent = 0;
		now = $urandom();
		while (sent < n) begin
			if ($urandom_range(99) < 15) begin
				send_item(random_item());
				sent++;
			end else begin
				it = random_item();
				it.opcode = arc_pkg::OP_START;
				send_item(it);
				sent++;
				depth = longint'($urandom_range(60000));
				rode = depth + longint'($urandom_range(80000));
				ticks = $urandom_range(4, 40);
				repeat (ticks) begin
					now += $urandom_range(1500);
					if ($urandom_range(99) < 3)
						now = $urandom();
					if ($urandom_range(3) == 0)
						rode -= longint'($urandom_range(6000));
					depth += longint'(int'($urandom_range(400)) - 200);
					slack = longint'($urandom_range(24000)) - 2000;
					op = arc_pkg::OP_TICK;
					if ($urandom_range(99) < 3)
						op = arc_pkg::OP_STOP;
					else if ($urandom_range(99) < 3)
						op = arc_pkg::OP_START;
					it = make_item(op, rode, depth, slack, now,
						$urandom_range(99) < 70, $urandom_range(99) < 10);
					// occasionally scramble the lengths entirely
					if ($urandom_range(99) < 5) begin
						it.depth_mm = arc_pkg::LEN_W'($urandom());
						it.slack_mm = arc_pkg::LEN_W'($urandom());
					end
					send_item(it);
					sent++;
				end
				if ($urandom_range(1) == 1) begin
					send_item(make_item(arc_pkg::OP_STOP, rode, depth, 0, now,
						$urandom_range(1) == 1, 1'b0));
					sent++;
				end
			end
		end
	endtask

	// Walk the default registers through every phase and special case
	task automatic test_directed_cases();
		idle_pct = 0;
		stall_pct = 0;
		// tick and stop while not running, and the unused opcode
		send_item(make_item(arc_pkg::OP_TICK, 1048575, -1048576, -1048576, 32'hFFFF_FFFF,
			1, 1));
		send_item(make_item(arc_pkg::OP_STOP, 0, 0, 0, 0, 1, 0));
		send_item(make_item(OP_UNUSED, 50000, 10000, 5000, 1000, 1, 0));
		send_item(make_item(arc_pkg::OP_START, 0, 0, 0, 0, 0, 0));
		send_item(make_item(arc_pkg::OP_START, 0, 0, 0, 0, 0, 0));
		// busy controller holds, then a slack raise, then a pause on low slack
		send_item(make_item(arc_pkg::OP_TICK, 50000, 10000, 5000, 5000, 0, 1));
		send_item(make_item(arc_pkg::OP_TICK, 50000, 10000, 5000, 5000, 0, 0));
		send_item(make_item(arc_pkg::OP_TICK, 48000, 10000, 100, 6000, 1, 0));
		// slack is back but the cooldown still runs
		send_item(make_item(arc_pkg::OP_TICK, 48000, 10000, 5000, 7000, 0, 0));
		// rode at completion leaves waiting regardless of cooldown
		send_item(make_item(arc_pkg::OP_TICK, 1500, 10000, 0, 7500, 0, 0));
		// final-pull zone before the cooldown ends, then after
		send_item(make_item(arc_pkg::OP_TICK, 15000, 10000, 0, 7600, 0, 0));
		send_item(make_item(arc_pkg::OP_TICK, 15000, 10000, 0, 9000, 0, 0));
		send_item(make_item(arc_pkg::OP_TICK, 15000, 10000, 0, 9100, 0, 0));
		send_item(make_item(arc_pkg::OP_TICK, 15000, 10000, 0, 9200, 0, 0));
		// final pull too short to command, then completion with winch moving
		send_item(make_item(arc_pkg::OP_TICK, 2050, 10000, 0, 12100, 0, 0));
		send_item(make_item(arc_pkg::OP_TICK, 2050, 10000, 0, 12200, 0, 0));
		send_item(make_item(arc_pkg::OP_TICK, 2000, 10000, 0, 12300, 1, 0));
		// stop while running, winch still and moving
		send_item(make_item(arc_pkg::OP_START, 0, 0, 0, 0, 0, 0));
		send_item(make_item(arc_pkg::OP_STOP, 0, 0, 0, 0, 0, 0));
		send_item(make_item(arc_pkg::OP_START, 0, 0, 0, 0, 0, 0));
		send_item(make_item(arc_pkg::OP_STOP, 0, 0, 0, 0, 1, 0));
		// field extremes: widest raise, time at its top, most negative rode
		send_item(make_item(arc_pkg::OP_START, 0, 0, 0, 0, 0, 0));
		send_item(make_item(arc_pkg::OP_TICK, 1048575, -1048576, 1048575, 32'hFFFF_FFFF,
			0, 0));
		send_item(make_item(arc_pkg::OP_TICK, -1048576, 0, 0, 32'hFFFF_FFFF, 0, 0));
		send_item(make_item(arc_pkg::OP_TICK, -1048576, 0, 0, 0, 0, 0));
		send_item(make_item(arc_pkg::OP_TICK, -1048576, 0, 0, 0, 1, 1));
	endtask

	// All registers at zero, then all at their widest value, then back to the defaults
	task automatic test_config_extremes();
		arc_pkg::cfg_t c;
		c = '0;
		apply_config(c);
		idle_pct = 50;
		stall_pct = 0;
		run_retrievals(150);
		c = '1;
		apply_config(c);
		idle_pct = 0;
		stall_pct = 50;
		run_retrievals(150);
		apply_config(DEFAULT_CFG);
		idle_pct = 20;
		stall_pct = 20;
		run_retrievals(150);
	endtask

	// Random registers under each flow-control pattern
	task automatic test_random_retrievals();
		int pattern;
		for (pattern = 0; pattern < 4; pattern++) begin
			apply_config(random_config());
			case (pattern)
				0: begin idle_pct = 0; stall_pct = 0; end
				1: begin idle_pct = 50; stall_pct = 0; end
				2: begin idle_pct = 0; stall_pct = 50; end
				default: begin idle_pct = 20; stall_pct = 20; end
			endcase
			run_retrievals(250);
		end
	endtask

	task automatic flag_field(string name, logic [31:0] expected_val, logic [31:0] got);
		if (got !== expected_val) begin
			$display("%0t: %s expected %0d actual %0d", $realtime, name, expected_val, got);
			n_errors++;
		end
	endtask

	// Receiver: randomize the stall and check every accepted result
	always @(posedge clk) begin
		out_stall <= ($urandom_range(99) < stall_pct);
		if (arst_n && out_valid && !out_stall) begin
			if (awaited_outcomes.size() == 0) begin
				$display("%0t: unexpected result, expected none actual command %0d phase %0d",
					$realtime, motor_command, phase);
				n_errors++;
			end else begin
				want = awaited_outcomes.pop_front();
				flag_field("motor_command", want.motor_command, motor_command);
				flag_field("raise_mm", want.raise_mm, raise_mm);
				flag_field("phase", want.phase, phase);
				flag_field("is_running", want.is_running, is_running);
				flag_field("is_complete", want.is_complete, is_complete);
				flag_field("finished_pulse", want.finished_pulse, finished_pulse);
				n_checked++;
			end
		end
	end

	// Watchdog: drop the run if neither channel moves for too long
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("%0t: no transaction for %0d cycles", $realtime, WATCHDOG_LIMIT);
				$display("** anchor_retrieval_sequencer: FAILED **");
				$finish;
			end
		end
	end

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_cases();
		test_config_extremes();
		test_random_retrievals();
		drain_results();
		// let any stray result surface before judging
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("Sent %0d transactions and checked %0d results across %0d register settings",
			n_items, n_checked, n_configs + 1);
		$display("Predicted %0d raise commands and %0d completed retrievals; %0d mismatches",
			n_raises, n_completions, n_errors);
		if (n_errors == 0 && awaited_outcomes.size() == 0) begin
			$display("** anchor_retrieval_sequencer: PASSED **");
		end else begin
			$display("** anchor_retrieval_sequencer: FAILED **");
		end
		$finish;
	end

endmodule

/* files.f */
+incdir+design
design/arc_pkg.sv
design/arc_cfg_regs.sv
design/arc_step_logic.sv
design/anchor_retrieval_sequencer.sv
tb/sv/anchor_retrieval_sequencer_tb.sv
